>>> sv/ipv4_option_checker_top_assert.svh
// Assertion macros for the option checker.
`ifndef IPV4_OPTION_CHECKER_TOP_ASSERT_SVH
`define IPV4_OPTION_CHECKER_TOP_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define IOC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define IOC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> sv/ioc_pkg.sv
package ioc_pkg;

   localparam int MAX_HEADER_BYTES_DEFAULT = 60;
   localparam int POS_W = 6;
   localparam logic [5:0] BASE_LEN = 6'd20;

   localparam logic [7:0] OPT_END  = 8'd0;
   localparam logic [7:0] OPT_NOP  = 8'd1;
   localparam logic [7:0] OPT_RR   = 8'd7;
   localparam logic [7:0] OPT_TS   = 8'd68;
   localparam logic [7:0] OPT_LSRR = 8'd131;
   localparam logic [7:0] OPT_SSRR = 8'd137;

   localparam logic [3:0] TS_ONLY    = 4'd0;
   localparam logic [3:0] TS_ADDR    = 4'd1;
   localparam logic [3:0] TS_PRESPEC = 4'd3;

   localparam logic [1:0] ST_ACCEPTED = 2'd0;
   localparam logic [1:0] ST_MALFORMED = 2'd1;
   localparam logic [1:0] ST_SRC_ROUTE = 2'd2;
   localparam logic [1:0] ST_SHORT = 2'd3;

   localparam int SEEN_SRR = 0;
   localparam int SEEN_RR  = 1;
   localparam int SEEN_TS  = 2;

   localparam logic [1:0] CSR_RECORD_ADDRESS = 2'd0;
   localparam logic [1:0] CSR_STAMP_VALUE    = 2'd1;
   localparam logic [1:0] CSR_LOCAL_ADDRESS  = 2'd2;

   typedef struct packed {
      logic             we;
      logic [POS_W-1:0] wa;
      logic [7:0]       wd;
      logic [POS_W-1:0] ra;
   } mem_req_type;

endpackage

>>> sv/ioc_store.sv
module ioc_store #(
   parameter int DEPTH = 60
) (
   input  logic                clock,
   input  ioc_pkg::mem_req_type req,
   output logic [7:0]          rd_data_ff
);
   import ioc_pkg::*;

   localparam int AW = $clog2(DEPTH);

   logic [7:0] store_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (req.we) begin
         store_ff[req.wa[AW-1:0]] <= req.wd;
      end
      rd_data_ff <= store_ff[req.ra[AW-1:0]];
   end

endmodule

>>> sv/ioc_ctrl.sv
module ioc_ctrl #(
   parameter int MAX_HEADER_BYTES = 60
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic [7:0]           in_byte,
   input  logic                 in_last,
   output logic                 out_valid_ff,
   input  logic                 out_ready,
   output logic [7:0]           out_byte_ff,
   output logic                 out_last_ff,
   output logic [8:0]           out_user_ff,
   input  logic [31:0]          record_address,
   input  logic [31:0]          stamp_value,
   input  logic [31:0]          local_address,
   output ioc_pkg::mem_req_type mem_req,
   input  logic [7:0]           rd_data
);
   import ioc_pkg::*;

   localparam logic [5:0] MAX_N = 6'(MAX_HEADER_BYTES);

   localparam logic [3:0] S_LOAD   = 4'd0;
   localparam logic [3:0] S_START  = 4'd1;
   localparam logic [3:0] S_WALK   = 4'd2;
   localparam logic [3:0] S_KIND   = 4'd3;
   localparam logic [3:0] S_LEN    = 4'd4;
   localparam logic [3:0] S_PTR    = 4'd5;
   localparam logic [3:0] S_FLG    = 4'd6;
   localparam logic [3:0] S_CMP    = 4'd7;
   localparam logic [3:0] S_PUT    = 4'd8;
   localparam logic [3:0] S_PTRW   = 4'd9;
   localparam logic [3:0] S_CLR    = 4'd10;
   localparam logic [3:0] S_CLRC   = 4'd11;
   localparam logic [3:0] S_OSTART = 4'd12;
   localparam logic [3:0] S_OLD    = 4'd13;
   localparam logic [3:0] S_OWT    = 4'd14;

   logic [3:0]  state_ff, state_in;
   logic [5:0]  count_ff, count_in;
   logic [3:0]  ihl_ff, ihl_in;
   logic [5:0]  pos_ff, pos_in;
   logic [5:0]  end_ff, end_in;
   logic [7:0]  kind_ff, kind_in;
   logic [7:0]  olen_ff, olen_in;
   logic [7:0]  ptr_ff, ptr_in;
   logic [2:0]  seen_ff, seen_in;
   logic        chg_ff, chg_in;
   logic [1:0]  status_ff, status_in;
   logic [5:0]  off_ff, off_in;
   logic [5:0]  base_ff, base_in;
   logic [2:0]  cnt_ff, cnt_in;
   logic [63:0] pdata_ff, pdata_in;
   logic [7:0]  npt_ff, npt_in;
   logic        miss_ff, miss_in;
   logic [5:0]  idx_ff, idx_in;
   logic        out_valid_in, out_last_in;
   logic [7:0]  out_byte_in;
   logic [8:0]  out_user_in;

   always_comb begin
      logic [5:0] left;
      logic [5:0] hl;
      logic [5:0] adv;
      logic [8:0] at9;
      logic [7:0] lbyte;
      logic       fault;
      logic [5:0] foff;
      left  = end_ff - pos_ff;
      hl    = {ihl_ff, 2'b00};
      adv   = 6'(9'(pos_ff) + 9'(olen_ff));
      at9   = 9'(pos_ff) + 9'(ptr_ff) - 9'd1;
      lbyte = 8'(local_address >> {cnt_ff - 3'd1, 3'b000});
      fault = 1'b0;
      foff  = '0;

      state_in = state_ff;
      count_in = count_ff;
      ihl_in = ihl_ff;
      pos_in = pos_ff;
      end_in = end_ff;
      kind_in = kind_ff;
      olen_in = olen_ff;
      ptr_in = ptr_ff;
      seen_in = seen_ff;
      chg_in = chg_ff;
      status_in = status_ff;
      off_in = off_ff;
      base_in = base_ff;
      cnt_in = cnt_ff;
      pdata_in = pdata_ff;
      npt_in = npt_ff;
      miss_in = miss_ff;
      idx_in = idx_ff;
      out_valid_in = out_valid_ff;
      out_byte_in = out_byte_ff;
      out_last_in = out_last_ff;
      out_user_in = out_user_ff;
      mem_req = '0;
      in_ready = (state_ff == S_LOAD);

      case (state_ff)
         S_LOAD: begin
            if (in_valid) begin
               if (count_ff < MAX_N) begin
                  mem_req.we = 1'b1;
                  mem_req.wa = count_ff;
                  mem_req.wd = in_byte;
                  count_in = count_ff + 6'd1;
                  if (count_ff == '0) begin
                     ihl_in = in_byte[3:0];
                  end
               end
               if (in_last) begin
                  state_in = S_START;
               end
            end
         end
         S_START: begin
            seen_in = '0;
            chg_in = 1'b0;
            status_in = ST_ACCEPTED;
            off_in = '0;
            idx_in = '0;
            state_in = S_OSTART;
            if (count_ff < BASE_LEN) begin
               status_in = ST_SHORT;
            end else if (hl < BASE_LEN) begin
               status_in = ST_MALFORMED;
            end else if (count_ff < hl) begin
               status_in = ST_SHORT;
            end else begin
               pos_in = BASE_LEN;
               end_in = hl;
               state_in = S_WALK;
            end
         end
         S_WALK: begin
            if (pos_ff >= end_ff) begin
               state_in = S_OSTART;
            end else begin
               mem_req.ra = pos_ff;
               state_in = S_KIND;
            end
         end
         S_KIND: begin
            kind_in = rd_data;
            if (rd_data == OPT_END) begin
               base_in = pos_ff + 6'd1;
               state_in = S_CLR;
            end else if (rd_data == OPT_NOP) begin
               pos_in = pos_ff + 6'd1;
               state_in = S_WALK;
            end else if (left < 6'd2) begin
               fault = 1'b1;
               foff = pos_ff;
            end else begin
               mem_req.ra = pos_ff + 6'd1;
               state_in = S_LEN;
            end
         end
         S_LEN: begin
            olen_in = rd_data;
            mem_req.ra = pos_ff + 6'd2;
            state_in = S_PTR;
            if (rd_data < 8'd2 || rd_data > 8'(left)) begin
               fault = 1'b1;
               foff = pos_ff;
            end else if (kind_ff == OPT_LSRR || kind_ff == OPT_SSRR) begin
               if (rd_data < 8'd3) begin
                  fault = 1'b1;
                  foff = pos_ff + 6'd1;
               end
            end else if (kind_ff == OPT_RR) begin
               if (seen_ff[SEEN_RR]) begin
                  fault = 1'b1;
                  foff = pos_ff;
               end else if (rd_data < 8'd3) begin
                  fault = 1'b1;
                  foff = pos_ff + 6'd1;
               end
            end else if (kind_ff == OPT_TS) begin
               if (seen_ff[SEEN_TS]) begin
                  fault = 1'b1;
                  foff = pos_ff;
               end else if (rd_data < 8'd4) begin
                  fault = 1'b1;
                  foff = pos_ff + 6'd1;
               end
            end else begin
               // unknown option: skip it whole
               pos_in = 6'(9'(pos_ff) + 9'(rd_data));
               state_in = S_WALK;
            end
         end
         S_PTR: begin
            ptr_in = rd_data;
            state_in = S_WALK;
            if (kind_ff == OPT_LSRR || kind_ff == OPT_SSRR) begin
               if (rd_data < 8'd4) begin
                  fault = 1'b1;
                  foff = pos_ff + 6'd2;
               end else if (seen_ff[SEEN_SRR]) begin
                  fault = 1'b1;
                  foff = pos_ff;
               end else begin
                  seen_in[SEEN_SRR] = 1'b1;
                  pos_in = adv;
               end
            end else if (kind_ff == OPT_RR) begin
               if (rd_data < 8'd4) begin
                  fault = 1'b1;
                  foff = pos_ff + 6'd2;
               end else if (rd_data <= olen_ff) begin
                  if (9'(rd_data) + 9'd3 > 9'(olen_ff)) begin
                     fault = 1'b1;
                     foff = pos_ff + 6'd2;
                  end else begin
                     seen_in[SEEN_RR] = 1'b1;
                     base_in = 6'(9'(pos_ff) + 9'(rd_data) - 9'd1);
                     pdata_in = {32'd0, record_address};
                     cnt_in = 3'd3;
                     npt_in = rd_data + 8'd4;
                     state_in = S_PUT;
                  end
               end else begin
                  seen_in[SEEN_RR] = 1'b1;
                  pos_in = adv;
               end
            end else begin
               if (rd_data < 8'd5) begin
                  fault = 1'b1;
                  foff = pos_ff + 6'd2;
               end else begin
                  mem_req.ra = pos_ff + 6'd3;
                  state_in = S_FLG;
               end
            end
         end
         S_FLG: begin
            state_in = S_PUT;
            base_in = 6'(at9);
            if (ptr_ff <= olen_ff) begin
               if (9'(ptr_ff) + 9'd3 > 9'(olen_ff)) begin
                  fault = 1'b1;
                  foff = pos_ff + 6'd2;
               end else if (rd_data[3:0] == TS_ONLY) begin
                  seen_in[SEEN_TS] = 1'b1;
                  pdata_in = {32'd0, stamp_value};
                  cnt_in = 3'd3;
                  npt_in = ptr_ff + 8'd4;
               end else if (rd_data[3:0] == TS_ADDR || rd_data[3:0] == TS_PRESPEC) begin
                  if (9'(ptr_ff) + 9'd7 > 9'(olen_ff)) begin
                     fault = 1'b1;
                     foff = pos_ff + 6'd2;
                  end else begin
                     seen_in[SEEN_TS] = 1'b1;
                     npt_in = ptr_ff + 8'd8;
                     if (rd_data[3:0] == TS_ADDR) begin
                        pdata_in = {stamp_value, record_address};
                        cnt_in = 3'd7;
                     end else begin
                        cnt_in = '0;
                        miss_in = 1'b0;
                        state_in = S_CMP;
                     end
                  end
               end else begin
                  fault = 1'b1;
                  foff = pos_ff + 6'd3;
               end
            end else begin
               // full option: bump the overflow nibble
               if (rd_data[7:4] == 4'hF) begin
                  fault = 1'b1;
                  foff = pos_ff + 6'd3;
               end else begin
                  seen_in[SEEN_TS] = 1'b1;
                  mem_req.we = 1'b1;
                  mem_req.wa = pos_ff + 6'd3;
                  mem_req.wd = rd_data + 8'd16;
                  chg_in = 1'b1;
                  pos_in = adv;
                  state_in = S_WALK;
               end
            end
         end
         S_CMP: begin
            // compare the prespecified address one byte a cycle
            mem_req.ra = base_ff + 6'(cnt_ff);
            cnt_in = cnt_ff + 3'd1;
            if (cnt_ff != '0 && rd_data != lbyte) begin
               miss_in = 1'b1;
            end
            if (cnt_ff == 3'd4) begin
               if (miss_in) begin
                  pos_in = adv;
                  state_in = S_WALK;
               end else begin
                  base_in = base_ff + 6'd4;
                  pdata_in = {32'd0, stamp_value};
                  cnt_in = 3'd3;
                  state_in = S_PUT;
               end
            end
         end
         S_PUT: begin
            mem_req.we = 1'b1;
            mem_req.wa = base_ff;
            mem_req.wd = pdata_ff[7:0];
            pdata_in = pdata_ff >> 8;
            base_in = base_ff + 6'd1;
            cnt_in = cnt_ff - 3'd1;
            chg_in = 1'b1;
            if (cnt_ff == '0) begin
               state_in = S_PTRW;
            end
         end
         S_PTRW: begin
            mem_req.we = 1'b1;
            mem_req.wa = pos_ff + 6'd2;
            mem_req.wd = npt_ff;
            pos_in = adv;
            state_in = S_WALK;
         end
         S_CLR: begin
            if (base_ff >= end_ff) begin
               state_in = S_OSTART;
            end else begin
               mem_req.ra = base_ff;
               state_in = S_CLRC;
            end
         end
         S_CLRC: begin
            if (rd_data != 8'd0) begin
               mem_req.we = 1'b1;
               mem_req.wa = base_ff;
               chg_in = 1'b1;
            end
            base_in = base_ff + 6'd1;
            state_in = S_CLR;
         end
         S_OSTART: begin
            if (status_ff == ST_ACCEPTED && seen_ff[SEEN_SRR]) begin
               status_in = ST_SRC_ROUTE;
            end
            mem_req.ra = idx_ff;
            state_in = S_OLD;
         end
         S_OLD: begin
            out_valid_in = 1'b1;
            out_byte_in = rd_data;
            out_last_in = (idx_ff + 6'd1 == count_ff);
            out_user_in = out_last_in ? {chg_ff, off_ff, status_ff} : '0;
            state_in = S_OWT;
         end
         S_OWT: begin
            if (out_ready) begin
               out_valid_in = 1'b0;
               if (out_last_ff) begin
                  count_in = '0;
                  seen_in = '0;
                  pos_in = '0;
                  state_in = S_LOAD;
               end else begin
                  idx_in = idx_ff + 6'd1;
                  mem_req.ra = idx_in;
                  state_in = S_OLD;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase

      if (fault) begin
         status_in = ST_MALFORMED;
         off_in = foff;
         state_in = S_OSTART;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         count_ff <= '0;
         seen_ff <= '0;
         pos_ff <= '0;
         out_valid_ff <= 1'b0;
         chg_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         seen_ff <= seen_in;
         pos_ff <= pos_in;
         out_valid_ff <= out_valid_in;
         chg_ff <= chg_in;
      end
      ihl_ff <= ihl_in;
      end_ff <= end_in;
      kind_ff <= kind_in;
      olen_ff <= olen_in;
      ptr_ff <= ptr_in;
      status_ff <= status_in;
      off_ff <= off_in;
      base_ff <= base_in;
      cnt_ff <= cnt_in;
      pdata_ff <= pdata_in;
      npt_ff <= npt_in;
      miss_ff <= miss_in;
      idx_ff <= idx_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
      out_user_ff <= out_user_in;
   end

endmodule

>>> sv/ipv4_option_checker_top.sv
// IPv4 option checker: takes one header byte per transfer on req_ (tlast on the final byte),
// buffers up to MAX_HEADER_BYTES bytes in a single-port-write header memory, then walks the
// option area from byte 20 to IHL*4 and rewrites record-route and timestamp options in place.
// Every buffered byte then leaves on rsp_ in original order; the last transfer carries the
// verdict (accepted, malformed with offset, source route present, short header) and the
// changed flag. Per packet the block takes one input byte per cycle while req_tvalid is high,
// checks the header, examines each option (one memory read per examined byte), compares a
// prespecified timestamp address, writes each rewritten slot byte and then the pointer,
// reads the bytes after an End option and clears any that are nonzero, then sends the bytes
// one at a time, reading each through the one read port after the previous one is taken.
// Input is refused from the last input byte until the last output transfer. Write the csr_
// registers only while no packet is in flight.
module ipv4_option_checker_top #(
   parameter int MAX_HEADER_BYTES = ioc_pkg::MAX_HEADER_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] header_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic        rsp_tlast,
   output logic [8:0]  rsp_tuser,   // [1:0] status, [7:2] problem_offset, [8] was_changed
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import ioc_pkg::*;

   `include "ipv4_option_checker_top_assert.svh"

   logic [31:0] record_address_ff;
   logic [31:0] stamp_value_ff;
   logic [31:0] local_address_ff;
   mem_req_type mem_req;
   logic [7:0]  rd_data;

   // Hold configuration; write the addressed register, drop writes beyond the list.
   always_ff @(posedge clock) begin
      if (reset) begin
         record_address_ff <= 32'd314159;
         stamp_value_ff <= 32'd1;
         local_address_ff <= 32'd0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RECORD_ADDRESS: record_address_ff <= csr_wdata;
            CSR_STAMP_VALUE:    stamp_value_ff <= csr_wdata;
            CSR_LOCAL_ADDRESS:  local_address_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Header buffer: one write and one registered read per cycle.
   ioc_store #(
      .DEPTH(MAX_HEADER_BYTES)
   ) u_store (
      .clock(clock),
      .req(mem_req),
      .rd_data_ff(rd_data)
   );

   // Load, walk, rewrite and emit sequencer.
   ioc_ctrl #(
      .MAX_HEADER_BYTES(MAX_HEADER_BYTES)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .in_valid(req_tvalid),
      .in_ready(req_tready),
      .in_byte(req_tdata),
      .in_last(req_tlast),
      .out_valid_ff(rsp_tvalid),
      .out_ready(rsp_tready),
      .out_byte_ff(rsp_tdata),
      .out_last_ff(rsp_tlast),
      .out_user_ff(rsp_tuser),
      .record_address(record_address_ff),
      .stamp_value(stamp_value_ff),
      .local_address(local_address_ff),
      .mem_req(mem_req),
      .rd_data(rd_data)
   );

   // Input and output phases never overlap.
   `IOC_ASSERT(a_no_overlap, !(req_tready && rsp_tvalid), "input taken while output pending")
   // Verdict fields only on the final byte.
   `IOC_ASSERT(a_user_last, (rsp_tvalid && !rsp_tlast) |-> (rsp_tuser == 9'd0), "status off last")
   // Reset leaves the output idle.
   `IOC_ASSERT_ALWAYS(a_reset_idle, reset |=> !rsp_tvalid, "output valid after reset")
   // A final transfer returns the block to input.
   `IOC_ASSERT(a_back_to_load, (rsp_tvalid && rsp_tready && rsp_tlast) |=> req_tready, "no reload")

endmodule

>>> sim/tb_ipv4_option_checker_top.sv
`timescale 1ns / 100ps

module tb_ipv4_option_checker_top;
   import ioc_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int LONG_HOLD      = 400;
   localparam int RANDOM_BYTES   = 45;

   // option shapes that the packet builder can lay down
   localparam int C_NOP    = 0;
   localparam int C_END    = 1;
   localparam int C_RR     = 2;
   localparam int C_TS0    = 3;
   localparam int C_TS1    = 4;
   localparam int C_TS3M   = 5;
   localparam int C_TS3X   = 6;
   localparam int C_TSFULL = 7;
   localparam int C_SRR    = 8;
   localparam int C_OTHER  = 9;
   localparam int C_JUNK   = 10;
   localparam int C_RANDOM = 11;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } byte_item_type;

   typedef struct {
      logic [7:0] data;
      logic       last;
      logic [8:0] user;
   } out_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;   // [7:0] header_byte
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;          // [7:0] out_byte
   logic        rsp_tlast;
   logic [8:0]  rsp_tuser;          // [1:0] status, [7:2] problem_offset, [8] was_changed
   logic        csr_we = 1'b0;
   logic [1:0]  csr_index = CSR_RECORD_ADDRESS;
   logic [31:0] csr_wdata = 32'd0;

   ipv4_option_checker_top uut (.*);

   // stimulus and expected-result stores
   byte_item_type pending_bytes[$];
   out_byte_type  expected_bytes[$];
   int          errors = 0;
   int          bytes_queued = 0;

   // predictor copy of the block's state and registers
   logic [7:0]  hdr[60];
   int          hdr_count = 0;
   logic [2:0]  seen;
   bit          changed;
   logic [31:0] rec_addr = 32'd314159;
   logic [31:0] stamp_val = 32'd1;
   logic [31:0] local_addr = 32'd0;

   // traffic shaping
   bit          no_idle = 1'b0;
   bit          long_hold_req = 1'b0;
   int          send_gap = 0;
   int          recv_stall = 0;
   int          hold_count = 0;
   int          watchdog = 0;

   // packet builder scratch
   logic [7:0]  pkt[80];

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report(string what, logic [31:0] exp_v, logic [31:0] got_v);
      $display("mismatch %s: expected %0h, got %0h at %0t", what, exp_v, got_v, $realtime);
      errors++;
   endtask

   // ---------------------------------------------------------------- predictor
   function automatic void store_word(int at, logic [31:0] v);
      for (int i = 0; i < 4; i++) hdr[(at + i) % 60] = v[8*i +: 8];
      changed = 1'b1;
   endfunction

   function automatic logic [31:0] fetch_word(int at);
      logic [31:0] v;
      for (int i = 0; i < 4; i++) v[8*i +: 8] = hdr[(at + i) % 60];
      return v;
   endfunction

   // Walk options in [20, stop); return 0 if fine, else fault offset + 1.
   function automatic int walk_options(int stop);
      int p, left, olen, ptr, flags;
      logic [7:0] kind;
      logic [3:0] mode;
      p = 20;
      while (p < stop) begin
         left = stop - p;
         kind = hdr[p];
         if (kind == OPT_END) begin
            // clear every remaining option byte
            for (int q = p + 1; q < stop; q++) begin
               if (hdr[q] != 8'd0) begin
                  hdr[q] = 8'd0;
                  changed = 1'b1;
               end
            end
            return 0;
         end
         if (kind == OPT_NOP) begin
            p++;
            continue;
         end
         if (left < 2) return p + 1;
         olen = hdr[p + 1];
         if (olen < 2 || olen > left) return p + 1;
         if (kind == OPT_LSRR || kind == OPT_SSRR) begin
            if (olen < 3) return p + 2;
            if (hdr[p + 2] < 4) return p + 3;
            if (seen[SEEN_SRR]) return p + 1;
            seen[SEEN_SRR] = 1'b1;
         end else if (kind == OPT_RR) begin
            if (seen[SEEN_RR]) return p + 1;
            if (olen < 3) return p + 2;
            ptr = hdr[p + 2];
            if (ptr < 4) return p + 3;
            if (ptr <= olen) begin
               if (ptr + 3 > olen) return p + 3;
               store_word(p + ptr - 1, rec_addr);
               hdr[p + 2] = 8'(ptr + 4);
            end
            seen[SEEN_RR] = 1'b1;
         end else if (kind == OPT_TS) begin
            if (seen[SEEN_TS]) return p + 1;
            if (olen < 4) return p + 2;
            ptr = hdr[p + 2];
            if (ptr < 5) return p + 3;
            if (ptr <= olen) begin
               mode = hdr[p + 3][3:0];
               if (ptr + 3 > olen) return p + 3;
               if (mode == TS_ONLY) begin
                  seen[SEEN_TS] = 1'b1;
                  store_word(p + ptr - 1, stamp_val);
                  hdr[p + 2] = 8'(ptr + 4);
               end else if (mode == TS_ADDR || mode == TS_PRESPEC) begin
                  if (ptr + 7 > olen) return p + 3;
                  seen[SEEN_TS] = 1'b1;
                  if (mode == TS_ADDR) begin
                     store_word(p + ptr - 1, rec_addr);
                  end else if (fetch_word(p + ptr - 1) != local_addr) begin
                     // entry is for another hop: skip untouched
                     p = p + olen;
                     continue;
                  end
                  store_word(p + ptr + 3, stamp_val);
                  hdr[p + 2] = 8'(ptr + 8);
               end else begin
                  return p + 4;
               end
            end else begin
               // option full: bump the overflow nibble unless it saturates
               flags = hdr[p + 3];
               if (flags[7:4] == 4'hF) return p + 4;
               seen[SEEN_TS] = 1'b1;
               hdr[p + 3] = 8'(flags + 16);
               changed = 1'b1;
            end
         end
         p = p + olen;
      end
      return 0;
   endfunction

   // Work out the verdict and queue one expected transfer per buffered byte.
   function automatic void predict_packet();
      int hl, fault;
      logic [1:0] status;
      logic [5:0] offset;
      out_byte_type ob;
      status  = ST_ACCEPTED;
      offset  = 6'd0;
      changed = 1'b0;
      seen    = 3'b000;
      if (hdr_count < 20) begin
         status = ST_SHORT;
      end else begin
         hl = hdr[0][3:0] * 4;
         if (hl < 20) begin
            status = ST_MALFORMED;
         end else if (hdr_count < hl) begin
            status = ST_SHORT;
         end else begin
            fault = walk_options(hl);
            if (fault != 0) begin
               status = ST_MALFORMED;
               offset = 6'(fault - 1);
            end else if (seen[SEEN_SRR]) begin
               status = ST_SRC_ROUTE;
            end
         end
      end
      for (int i = 0; i < hdr_count; i++) begin
         ob.data = hdr[i];
         ob.last = (i + 1 == hdr_count);
         ob.user = ob.last ? {changed, offset, status} : 9'd0;
         expected_bytes.push_back(ob);
      end
      hdr_count = 0;
   endfunction

   // ---------------------------------------------------------------- stimulus
   function automatic void put_le(int at, logic [31:0] v);
      for (int i = 0; i < 4; i++) pkt[at + i] = v[8*i +: 8];
   endfunction

   // Lay one option at pos within rem bytes; return its length.
   function automatic int lay_option(int choice, int pos, int rem);
      int k, j, olen;
      logic [7:0] kind;
      logic [3:0] mode;
      if (choice == C_RANDOM) begin
         case ($urandom_range(0, 15))
            0, 1:    choice = C_NOP;
            2:       choice = C_END;
            3, 4:    choice = C_RR;
            5:       choice = C_TS0;
            6:       choice = C_TS1;
            7:       choice = C_TS3M;
            8:       choice = C_TS3X;
            9:       choice = C_TSFULL;
            10, 11:  choice = C_SRR;
            12, 13:  choice = C_OTHER;
            default: choice = C_JUNK;
         endcase
      end
      case (choice)
         C_END: begin
            pkt[pos] = OPT_END;
            return rem;
         end
         C_RR, C_SRR: begin
            if (rem >= 3) begin
               k = $urandom_range(0, (rem - 3) / 4);
               j = $urandom_range(0, k);
               kind = (choice == C_RR) ? OPT_RR
                                       : ($urandom_range(0, 1) ? OPT_LSRR : OPT_SSRR);
               pkt[pos] = kind;
               pkt[pos + 1] = 8'(3 + 4 * k);
               pkt[pos + 2] = 8'(4 + 4 * j);
               return 3 + 4 * k;
            end
         end
         C_TS0: begin
            if (rem >= 8) begin
               k = $urandom_range(1, (rem - 4) / 4);
               j = $urandom_range(0, k);
               pkt[pos] = OPT_TS;
               pkt[pos + 1] = 8'(4 + 4 * k);
               pkt[pos + 2] = 8'(5 + 4 * j);
               pkt[pos + 3] = {4'($urandom_range(0, 14)), TS_ONLY};
               return 4 + 4 * k;
            end
         end
         C_TS1, C_TS3M, C_TS3X: begin
            if (rem >= 12) begin
               k = $urandom_range(1, (rem - 4) / 8);
               j = $urandom_range(0, k - 1);
               mode = (choice == C_TS1) ? TS_ADDR : TS_PRESPEC;
               pkt[pos] = OPT_TS;
               pkt[pos + 1] = 8'(4 + 8 * k);
               pkt[pos + 2] = 8'(5 + 8 * j);
               pkt[pos + 3] = {4'($urandom_range(0, 14)), mode};
               if (choice == C_TS3M) put_le(pos + 4 + 8 * j, local_addr);
               return 4 + 8 * k;
            end
         end
         C_TSFULL: begin
            if (rem >= 4) begin
               olen = 4 + 4 * $urandom_range(0, (rem - 4) / 4);
               pkt[pos] = OPT_TS;
               pkt[pos + 1] = 8'(olen);
               pkt[pos + 2] = 8'(olen + 1);
               pkt[pos + 3] = 8'($urandom_range(0, 255));
               return olen;
            end
         end
         C_OTHER: begin
            if (rem >= 2) begin
               do kind = 8'($urandom_range(2, 255));
               while (kind == OPT_RR || kind == OPT_TS || kind == OPT_LSRR || kind == OPT_SSRR);
               olen = $urandom_range(2, rem);
               pkt[pos] = kind;
               pkt[pos + 1] = 8'(olen);
               return olen;
            end
         end
         C_JUNK: begin
            return 1;
         end
         default: ;
      endcase
      pkt[pos] = OPT_NOP;
      return 1;
   endfunction

   // Build a header with the given IHL, the first option forced to first_choice.
   function automatic void build_header(int ihl, int first_choice, bit corrupt);
      int pos, stop, choice;
      foreach (pkt[i]) pkt[i] = 8'($urandom_range(0, 255));
      pkt[0] = {4'h4, 4'(ihl)};
      stop = ihl * 4;
      pos = 20;
      choice = first_choice;
      while (pos < stop) begin
         pos += lay_option(choice, pos, stop - pos);
         choice = C_RANDOM;
      end
      if (corrupt && stop > 20) pkt[$urandom_range(20, stop - 1)] = 8'($urandom_range(0, 255));
   endfunction

   task automatic queue_packet(int len);
      byte_item_type it;
      for (int i = 0; i < len; i++) begin
         it.data = (i < 80) ? pkt[i] : 8'($urandom_range(0, 255));
         it.last = (i == len - 1);
         pending_bytes.push_back(it);
      end
      bytes_queued += len;
   endtask

   task automatic directed_packet(int ihl, int first_choice, int extra);
      build_header(ihl, first_choice, 1'b0);
      queue_packet(ihl * 4 + extra);
   endtask

   task automatic random_packet();
      int ihl;
      if ($urandom_range(0, 9) == 0) begin
         // noise: any length, any content
         foreach (pkt[i]) pkt[i] = 8'($urandom_range(0, 255));
         queue_packet($urandom_range(1, 70));
      end else begin
         ihl = $urandom_range(5, 15);
         build_header(ihl, C_RANDOM, $urandom_range(0, 7) == 0);
         queue_packet(ihl * 4 + (($urandom_range(0, 5) == 0) ? $urandom_range(1, 12) : 0));
      end
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_bytes.size() != 0 || req_tvalid || expected_bytes.size() != 0
             || hdr_count != 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_RECORD_ADDRESS: rec_addr   = value;
         CSR_STAMP_VALUE:    stamp_val  = value;
         default:            local_addr = value;
      endcase
   endtask

   task automatic write_all_csr(logic [31:0] ra, logic [31:0] sv, logic [31:0] la);
      write_csr(CSR_RECORD_ADDRESS, ra);
      write_csr(CSR_STAMP_VALUE, sv);
      write_csr(CSR_LOCAL_ADDRESS, la);
   endtask

   task automatic random_phase(int nbytes);
      int stop;
      stop = bytes_queued + nbytes;
      while (bytes_queued < stop) random_packet();
   endtask

   // ---------------------------------------------------------------- sequence
   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed: reset register values first
      foreach (pkt[i]) pkt[i] = 8'($urandom_range(0, 255));
      queue_packet(10);                      // short of a base header
      pkt[0] = 8'h43;
      queue_packet(20);                      // IHL below five
      build_header(6, C_RR, 1'b0);
      queue_packet(22);                      // fewer bytes than IHL says
      directed_packet(6, C_RR, 4);           // bytes past the option area
      directed_packet(15, C_TS0, 1);         // over-long: count saturates
      directed_packet(8, C_TS1, 0);
      directed_packet(6, C_TSFULL, 0);
      directed_packet(6, C_SRR, 0);
      directed_packet(6, C_END, 0);
      build_header(6, C_NOP, 1'b0);
      pkt[20] = OPT_NOP; pkt[21] = OPT_NOP; pkt[22] = OPT_NOP; pkt[23] = OPT_RR;
      queue_packet(24);                      // option kind as the last option byte
      build_header(9, C_RR, 1'b0);
      pkt[20] = OPT_RR; pkt[21] = 8'd7; pkt[22] = 8'd4;
      pkt[27] = OPT_RR; pkt[28] = 8'd3; pkt[29] = 8'd4;
      pkt[30] = OPT_LSRR; pkt[31] = 8'd2;
      queue_packet(36);                      // duplicate record route after a rewrite
      build_header(7, C_NOP, 1'b0);
      pkt[20] = OPT_TS; pkt[21] = 8'd4; pkt[22] = 8'd5; pkt[23] = 8'hF0;
      queue_packet(28);                      // overflow nibble saturated
      build_header(7, C_NOP, 1'b0);
      pkt[20] = OPT_TS; pkt[21] = 8'd8; pkt[22] = 8'd5; pkt[23] = 8'h05;
      queue_packet(28);                      // unknown timestamp flag mode
      wait_idle();

      // extremes of the registers
      write_all_csr(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
      directed_packet(8, C_TS3M, 0);
      wait_idle();
      write_all_csr(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000);
      directed_packet(5, C_NOP, 0);
      random_phase(RANDOM_BYTES / 3);
      // hold the receiver off while the sender keeps offering
      long_hold_req <= 1'b1;
      wait_idle();

      write_all_csr($urandom, $urandom, $urandom);
      random_phase(RANDOM_BYTES / 3);
      wait_idle();

      // drain the last part with no idling on either side
      write_all_csr($urandom, $urandom, $urandom);
      no_idle <= 1'b1;
      random_phase(RANDOM_BYTES / 3);
      wait_idle();
      repeat (200) @(posedge clock);

      if (errors == 0 && expected_bytes.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // ---------------------------------------------------------------- driver
   always @(posedge clock) begin
      byte_item_type it;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap > 0) begin
            send_gap   <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_bytes.size() > 0) begin
            it = pending_bytes.pop_front();
            req_tdata  <= it.data;
            req_tlast  <= it.last;
            req_tvalid <= 1'b1;
            if (!no_idle && $urandom_range(0, 15) == 0) send_gap <= $urandom_range(1, 14);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------- receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (long_hold_req) begin
         long_hold_req <= 1'b0;
         hold_count    <= LONG_HOLD;
         rsp_tready    <= 1'b0;
      end else if (hold_count > 0) begin
         hold_count <= hold_count - 1;
         rsp_tready <= 1'b0;
      end else if (no_idle) begin
         rsp_tready <= 1'b1;
      end else if (recv_stall > 0) begin
         recv_stall <= recv_stall - 1;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 11) == 0) begin
         recv_stall <= $urandom_range(0, 13);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------- monitor
   always @(posedge clock) begin
      out_byte_type e;
      if (!reset && req_tvalid && req_tready) begin
         // buffer the transfer; bytes past the store's depth are dropped
         if (hdr_count < 60) begin
            hdr[hdr_count] = req_tdata;
            hdr_count++;
         end
         if (req_tlast) predict_packet();
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_bytes.size() == 0) begin
            report("unexpected transfer", 32'd0, {23'd0, rsp_tuser});
         end else begin
            e = expected_bytes.pop_front();
            if (rsp_tdata !== e.data) report("out_byte", e.data, rsp_tdata);
            if (rsp_tlast !== e.last) report("out_last", e.last, rsp_tlast);
            if (rsp_tuser[1:0] !== e.user[1:0]) report("status", e.user[1:0], rsp_tuser[1:0]);
            if (rsp_tuser[7:2] !== e.user[7:2])
               report("problem_offset", e.user[7:2], rsp_tuser[7:2]);
            if (rsp_tuser[8] !== e.user[8]) report("was_changed", e.user[8], rsp_tuser[8]);
         end
      end
   end

   // ---------------------------------------------------------------- watchdog
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         watchdog <= 0;
      end else if (watchdog >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         watchdog <= watchdog + 1;
      end
   end

endmodule
